>>> rtl/idp_pkg.sv
// Shared widths, constants and types of the interval product block.
`timescale 1ns / 1ps
package idp_pkg;

   localparam int VALUE_W = 8;
   localparam int TOTAL_W = 30;
   localparam int PIJ_W   = 2 * VALUE_W;
   localparam int PROD_W  = 3 * VALUE_W;
   localparam int SUM_W   = TOTAL_W + 1;
   localparam int CAND_W  = TOTAL_W + 2;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // Commands from the sequencer to the shared multiply-accumulate unit.
   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
   } mac_cmd_type;

endpackage

>>> rtl/idp_if.sv
// Request and response channel interfaces of the interval product block.
`timescale 1ns / 1ps
interface idp_req_if import idp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic               last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

interface idp_rsp_if import idp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TOTAL_W-1:0] max_total;
   logic               overflow;

   modport source (output valid, output max_total, output overflow, input ready);
   modport sink (input valid, input max_total, input overflow, output ready);
endinterface

>>> rtl/idp_ram.sv
// Simple RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module idp_ram #(
   parameter int DW    = 8,
   parameter int ABITS = 6
) (
   input  logic             clock,
   input  logic             we,
   input  logic [ABITS-1:0] waddr,
   input  logic [DW-1:0]    wdata,
   input  logic [ABITS-1:0] raddr_a,
   input  logic [ABITS-1:0] raddr_b,
   output logic [DW-1:0]    rdata_a,
   output logic [DW-1:0]    rdata_b
);

   logic [DW-1:0] mem [2**ABITS];
   logic [DW-1:0] rdata_a_ff;
   logic [DW-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

>>> rtl/idp_mac.sv
// Shared multiply, add, saturate and running-maximum unit.
`timescale 1ns / 1ps
module idp_mac import idp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  mac_cmd_type        cmd,
   input  logic [PIJ_W-1:0]   mul_a,
   input  logic [VALUE_W-1:0] mul_b,
   input  logic [TOTAL_W-1:0] t_left,
   input  logic [TOTAL_W-1:0] t_right,
   output logic [PROD_W-1:0]  prod,
   output logic [TOTAL_W-1:0] best,
   output logic               busy
);

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [SUM_W-1:0]   tsum_ff, tsum_in;
   logic               acc_v_ff;
   logic [TOTAL_W-1:0] best_ff, best_in;
   logic [CAND_W-1:0]  cand;
   logic [TOTAL_W-1:0] cand_sat;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign tsum_in = SUM_W'(t_left) + SUM_W'(t_right);

   assign cand     = CAND_W'(prod_ff) + CAND_W'(tsum_ff);
   assign cand_sat = (cand > CAND_W'(TOTAL_MAX)) ? TOTAL_MAX : cand[TOTAL_W-1:0];

   always_comb begin
      best_in = best_ff;
      if (cmd.clear) begin
         best_in = '0;
      end else if (acc_v_ff && (cand_sat > best_ff)) begin
         best_in = cand_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_v_ff <= 1'b0;
      end else begin
         acc_v_ff <= cmd.acc_en;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_en) begin
         tsum_ff <= tsum_in;
      end
      best_ff <= best_in;
   end

   assign prod = prod_ff;
   assign best = best_ff;
   assign busy = acc_v_ff;

endmodule

>>> rtl/interval_dp_max_triple_product.sv
// Top level: list loader, interval table sequencer and result register.
//
//   channel | dir | fields                 | transfer
//   --------+-----+------------------------+----------------------
//   req_if  | in  | value[7:0], last       | valid && ready
//   rsp_if  | out | max_total[29:0], overflow | valid && ready
//
// Values load at one request per cycle; the request with last set starts the run.
// Table entries are worked out one after another by the single multiply-accumulate
// unit from the table RAM; an overflowed list answers at once.
// No request is taken while the table fills or the response waits for ready.
// Reset is synchronous; the table needs no clearing pass after reset.
`timescale 1ns / 1ps
module interval_dp_max_triple_product import idp_pkg::*; #(
   parameter int MAX_ITEMS = 62
) (
   input logic clock,
   input logic reset,
   idp_req_if.sink   req_if,
   idp_rsp_if.source rsp_if
);

   localparam int AW = $clog2(MAX_ITEMS + 2);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   localparam logic [2:0] ST_LOAD   = 3'd0;
   localparam logic [2:0] ST_PREAD  = 3'd1;
   localparam logic [2:0] ST_PMUL   = 3'd2;
   localparam logic [2:0] ST_PCAP   = 3'd3;
   localparam logic [2:0] ST_ISSUE  = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;
   localparam logic [2:0] ST_WRITE  = 3'd6;
   localparam logic [2:0] ST_RESULT = 3'd7;

   logic [2:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               too_many_ff, too_many_in;
   logic [AW-1:0]      last_ff, last_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [AW-1:0]      j_ff, j_in;
   logic [AW-1:0]      l_ff, l_in;
   logic [PIJ_W-1:0]   pij_ff, pij_in;
   logic               pad_i_ff, pad_i_in;
   logic               pad_j_ff, pad_j_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               zero_il_ff, zero_il_in;
   logic               zero_lj_ff, zero_lj_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               ovf_ff, ovf_in;

   logic               req_fire;
   logic               p_we;
   logic [AW-1:0]      p_waddr, p_raddr_a;
   logic [VALUE_W-1:0] p_rd_a, p_rd_b;
   logic [VALUE_W-1:0] p_i, p_j;
   logic               t_we;
   logic [TOTAL_W-1:0] t_rd_a, t_rd_b;
   mac_cmd_type        mac_cmd;
   logic [PIJ_W-1:0]   mac_a;
   logic [VALUE_W-1:0] mac_b;
   logic [PROD_W-1:0]  mac_prod;
   logic [TOTAL_W-1:0] mac_best;
   logic               mac_busy;

   assign req_fire = req_if.valid && req_if.ready;

   // Padded values: position count+1 on load, read by i and j, then by l.
   assign p_we      = req_fire && (count_ff < CW'(MAX_ITEMS));
   assign p_waddr   = AW'(count_ff) + AW'(1);
   assign p_raddr_a = (state_ff == ST_ISSUE) ? l_ff : i_ff;

   idp_ram #(.DW(VALUE_W), .ABITS(AW)) u_pvals (
      .clock   (clock),
      .we      (p_we),
      .waddr   (p_waddr),
      .wdata   (req_if.value),
      .raddr_a (p_raddr_a),
      .raddr_b (j_ff),
      .rdata_a (p_rd_a),
      .rdata_b (p_rd_b)
   );

   // Entries of length one are never written and always read as zero.
   assign t_we = (state_ff == ST_WRITE);

   idp_ram #(.DW(TOTAL_W), .ABITS(2 * AW)) u_table (
      .clock   (clock),
      .we      (t_we),
      .waddr   ({i_ff, j_ff}),
      .wdata   (mac_best),
      .raddr_a ({i_ff, l_ff}),
      .raddr_b ({l_ff, j_ff}),
      .rdata_a (t_rd_a),
      .rdata_b (t_rd_b)
   );

   assign p_i = pad_i_ff ? VALUE_W'(1) : p_rd_a;
   assign p_j = pad_j_ff ? VALUE_W'(1) : p_rd_b;

   always_comb begin
      mac_cmd.clear  = (state_ff == ST_PCAP);
      mac_cmd.mul_en = (state_ff == ST_PMUL) || s1_valid_ff;
      mac_cmd.acc_en = s1_valid_ff;
      if (state_ff == ST_PMUL) begin
         mac_a = PIJ_W'(p_i);
         mac_b = p_j;
      end else begin
         mac_a = pij_ff;
         mac_b = p_rd_a;
      end
   end

   idp_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mac_cmd),
      .mul_a   (mac_a),
      .mul_b   (mac_b),
      .t_left  (zero_il_ff ? '0 : t_rd_a),
      .t_right (zero_lj_ff ? '0 : t_rd_b),
      .prod    (mac_prod),
      .best    (mac_best),
      .busy    (mac_busy)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      too_many_in = too_many_ff;
      last_in     = last_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      l_in        = l_ff;
      pij_in      = pij_ff;
      pad_i_in    = pad_i_ff;
      pad_j_in    = pad_j_ff;
      s1_valid_in = 1'b0;
      zero_il_in  = zero_il_ff;
      zero_lj_in  = zero_lj_ff;
      total_in    = total_ff;
      ovf_in      = ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  too_many_in = 1'b1;
               end
               if (req_if.last) begin
                  count_in    = '0;
                  too_many_in = 1'b0;
                  if (too_many_ff || (count_ff == CW'(MAX_ITEMS))) begin
                     total_in = '0;
                     ovf_in   = 1'b1;
                     state_in = ST_RESULT;
                  end else begin
                     // Right pad sits one past the value just stored.
                     last_in  = AW'(count_ff) + AW'(2);
                     i_in     = '0;
                     j_in     = AW'(2);
                     state_in = ST_PREAD;
                  end
               end
            end
         end
         ST_PREAD: begin
            pad_i_in = (i_ff == '0);
            pad_j_in = (j_ff == last_ff);
            state_in = ST_PMUL;
         end
         ST_PMUL: begin
            state_in = ST_PCAP;
         end
         ST_PCAP: begin
            pij_in   = mac_prod[PIJ_W-1:0];
            l_in     = i_ff + AW'(1);
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            s1_valid_in = 1'b1;
            zero_il_in  = (l_ff == i_ff + AW'(1));
            zero_lj_in  = (l_ff + AW'(1) == j_ff);
            if (l_ff + AW'(1) == j_ff) begin
               state_in = ST_DRAIN;
            end else begin
               l_in = l_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !mac_busy) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if ((i_ff == '0) && (j_ff == last_ff)) begin
               total_in = mac_best;
               ovf_in   = 1'b0;
               state_in = ST_RESULT;
            end else begin
               // Step along the diagonal, or start the next interval length.
               if (j_ff == last_ff) begin
                  i_in = '0;
                  j_in = j_ff - i_ff + AW'(1);
               end else begin
                  i_in = i_ff + AW'(1);
                  j_in = j_ff + AW'(1);
               end
               state_in = ST_PREAD;
            end
         end
         ST_RESULT: begin
            if (rsp_if.ready) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         too_many_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         too_many_ff <= too_many_in;
         s1_valid_ff <= s1_valid_in;
      end
      last_ff    <= last_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      l_ff       <= l_in;
      pij_ff     <= pij_in;
      pad_i_ff   <= pad_i_in;
      pad_j_ff   <= pad_j_in;
      zero_il_ff <= zero_il_in;
      zero_lj_ff <= zero_lj_in;
      total_ff   <= total_in;
      ovf_ff     <= ovf_in;
   end

   assign req_if.ready     = (state_ff == ST_LOAD);
   assign rsp_if.valid     = (state_ff == ST_RESULT);
   assign rsp_if.max_total = total_ff;
   assign rsp_if.overflow  = ovf_ff;

   a_split_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> ((l_ff > i_ff) && (l_ff < j_ff)))
      else $error("split point outside its interval");

   a_write_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (!s1_valid_ff && !mac_busy))
      else $error("table entry written while sums still in flight");

   a_write_order: assert property (@(posedge clock) disable iff (reset)
      t_we |-> ((j_ff > i_ff + AW'(1)) && (j_ff <= last_ff)))
      else $error("table write outside the padded range");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.overflow) |-> (rsp_if.max_total == '0))
      else $error("overflow response carries a nonzero total");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_if.last) |=> !req_if.ready)
      else $error("request taken before the run finished");

endmodule
